// ===== sv/mrlp_pkg.sv =====
// Shared types, constants and helpers of the protection region list programmer.
package mrlp_pkg;

  // Slot counter holds 0..16 so it needs one bit more than a slot number
  localparam int unsigned SlotCntW = 5;

  localparam logic [1:0] TypeNormal = 2'd0;
  localparam logic [1:0] TypeDevice = 2'd1;
  localparam logic [1:0] TypeShared = 2'd2;
  localparam logic [1:0] TypeStack  = 2'd3;

  localparam logic [4:0] MinExp = 5'd5;
  localparam logic [4:0] MaxExp = 5'd31;

  localparam logic [31:0] BaseValid    = 32'h0000_0010;
  localparam logic [31:0] AttrEnable   = 32'h0000_0001;
  localparam logic [31:0] AttrXn       = 32'h1000_0000;
  localparam logic [31:0] AttrApRw     = 32'h0300_0000;
  localparam logic [31:0] AttrApRo     = 32'h0600_0000;
  localparam logic [31:0] AttrMemNorm  = 32'h000F_0000;
  localparam logic [31:0] AttrMemDev   = 32'h0005_0000;
  localparam logic [31:0] AttrMemShare = 32'h0003_0000;

  typedef struct packed {
    logic [31:0] region_base;
    logic [31:0] region_size;
    logic [1:0]  region_perms;
    logic [1:0]  region_type;
    logic        kernel_space;
    logic        has_region;
    logic        last_region;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  slot_number;
    logic [31:0] base_word;
    logic [31:0] attr_word;
    logic        last_write;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_REGION,
    ST_FLUSH
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic search_start;
    logic search_step;
    logic emit_region;
    logic emit_disable;
    logic slot_reset;
  } dp_cmd_t;

  typedef struct packed {
    logic writes;     // descriptor takes a slot
    logic size_zero;
    logic last;
    logic hit;        // window at current exponent covers the region, or the largest exponent is reached
    logic slot_done;  // no slot left
    logic out_free;   // output register can take a word this cycle
  } dp_sts_t;

  function automatic logic [31:0] attr_bits(input logic [1:0] perms, input logic [1:0] rtype);
    logic [31:0] a;
    a = perms[0] ? AttrApRw : AttrApRo;
    if (!perms[1]) a = a | AttrXn;
    unique case (rtype)
      TypeDevice: a = a | AttrMemDev;
      TypeShared: a = a | AttrMemShare;
      default:    a = a | AttrMemNorm;
    endcase
    return a;
  endfunction

endpackage

// ===== sv/mrlp_ctrl.sv =====
// Sequencer of the region list programmer: input handshake and step control.
module mrlp_ctrl
  import mrlp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (sts_i.writes && sts_i.size_zero) begin
          state_d = ST_REGION;
        end else if (sts_i.writes) begin
          cmd_o.search_start = 1'b1;
          state_d            = ST_SEARCH;
        end else if (sts_i.last) begin
          state_d = ST_FLUSH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        if (sts_i.hit) begin
          state_d = ST_REGION;
        end else begin
          cmd_o.search_step = 1'b1;
        end
      end
      ST_REGION: begin
        if (sts_i.out_free) begin
          cmd_o.emit_region = 1'b1;
          state_d           = sts_i.last ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        priority if (sts_i.slot_done) begin
          cmd_o.slot_reset = 1'b1;
          state_d          = ST_IDLE;
        end else begin
          // waits here while the output register is stalled
          cmd_o.emit_disable = sts_i.out_free;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/mrlp_dp.sv =====
// Datapath: descriptor register, window search, slot counter and output register.
module mrlp_dp
  import mrlp_pkg::*;
#(
  parameter int unsigned NUM_SLOTS       = 8,
  parameter int unsigned FIRST_USER_SLOT = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_data_i,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output out_word_t out_data_o,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o
);

  localparam logic [SlotCntW-1:0] NumSlotsC = SlotCntW'(NUM_SLOTS);
  localparam logic [SlotCntW-1:0] FirstC    = SlotCntW'(FIRST_USER_SLOT);

  in_word_t            in_q;
  logic [31:0]         end_q;
  logic [4:0]          exp_q, exp_d;
  logic [SlotCntW-1:0] slot_q, slot_d, slot_next;
  logic                out_valid_q, out_valid_d;
  out_word_t           out_q, out_d;

  logic [31:0] wsize, wbase;
  logic        last_slot;

  assign wsize     = 32'd1 << exp_q;
  assign wbase     = in_q.region_base & ~(wsize - 32'd1);
  assign slot_next = slot_q + SlotCntW'(1);
  assign last_slot = slot_next >= NumSlotsC;

  assign sts_o.writes    = in_q.has_region && !in_q.kernel_space &&
                           (in_q.region_type != TypeStack) && (slot_q < NumSlotsC);
  assign sts_o.size_zero = in_q.region_size == 32'd0;
  assign sts_o.last      = in_q.last_region;
  // wrapping compare, stops at the largest window regardless
  assign sts_o.hit       = ((wbase + wsize) >= end_q) || (exp_q == MaxExp);
  assign sts_o.slot_done = slot_q >= NumSlotsC;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    exp_d       = exp_q;
    slot_d      = slot_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.search_start) exp_d = MinExp;
    if (cmd_i.search_step)  exp_d = exp_q + 5'd1;
    if (cmd_i.slot_reset)   slot_d = FirstC;
    if (cmd_i.emit_region) begin
      out_valid_d       = 1'b1;
      slot_d            = slot_next;
      out_d.slot_number = slot_q[3:0];
      out_d.last_write  = in_q.last_region && last_slot;
      if (sts_o.size_zero) begin
        out_d.base_word = 32'd0;
        out_d.attr_word = 32'd0;
      end else begin
        out_d.base_word = wbase | BaseValid | {28'd0, slot_q[3:0]};
        out_d.attr_word = AttrEnable | {26'd0, exp_q - 5'd1, 1'b0} |
                          attr_bits(in_q.region_perms, in_q.region_type);
      end
    end
    if (cmd_i.emit_disable) begin
      out_valid_d       = 1'b1;
      slot_d            = slot_next;
      out_d.slot_number = slot_q[3:0];
      out_d.base_word   = 32'd0;
      out_d.attr_word   = 32'd0;
      out_d.last_write  = last_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= FirstC;
      out_valid_q <= 1'b0;
    end else begin
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q  <= in_data_i;
      end_q <= in_data_i.region_base + in_data_i.region_size;
    end
    exp_q <= exp_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/mpu_region_list_programmer.sv =====
// Top level of the protection region list programmer.
// One descriptor word is taken at a time. A skipped descriptor passes through
// accept and check. A region of nonzero size then tries window exponents in turn,
// from 5 up to the first that covers base+size or up to 31, each by the single
// add-and-compare window test, then loads the output register. A descriptor
// with the last mark then writes a disabled word to each remaining slot and
// rewinds the slot counter. A stalled output with a word pending holds the output
// load and the disabled-slot writes. The next descriptor is accepted while the
// final word still waits in the output register.
module mpu_region_list_programmer
  import mrlp_pkg::*;
#(
  parameter int unsigned NUM_SLOTS       = 8,
  parameter int unsigned FIRST_USER_SLOT = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  mrlp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mrlp_dp #(
    .NUM_SLOTS       (NUM_SLOTS),
    .FIRST_USER_SLOT (FIRST_USER_SLOT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== sv/mrlp_checker.sv =====
// Port-level checks of the region list programmer, bound to the top level.
module mrlp_checker
  import mrlp_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 8
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_word_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_data_o
);

  localparam logic [SlotCntW-1:0] NumSlotsC = SlotCntW'(NUM_SLOTS);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word accepted while one is in work");

  a_disabled_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.base_word == 32'd0) == (out_data_o.attr_word == 32'd0)))
    else $error("base and attribute words disagree on enable");

  a_base_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.base_word != 32'd0) |->
      out_data_o.base_word[4] && (out_data_o.base_word[3:0] == out_data_o.slot_number)
      && out_data_o.attr_word[0])
    else $error("enabled word lacks valid bit or slot");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, out_data_o.slot_number} < NumSlotsC))
    else $error("slot number beyond table");

endmodule

bind mpu_region_list_programmer mrlp_checker #(.NUM_SLOTS(NUM_SLOTS)) u_mrlp_checker (.*);
